FILE: hw/rtl/audio_beat_detect_peak_hold_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the beat detector with peak hold
// Shared macros that wrap concurrent assertions on the block clock.
// ----------------------------------------------------------------------------
`ifndef AUDIO_BEAT_DETECT_PEAK_HOLD_DEFINES_SVH
`define AUDIO_BEAT_DETECT_PEAK_HOLD_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ABDPH_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ABDPH_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/abdph_pkg.sv
// ----------------------------------------------------------------------------
// Beat detector package
// Codes, reset values and helpers of the beat detector with peak hold.
// ----------------------------------------------------------------------------
package abdph_pkg;

    typedef enum logic [1:0] {
        OP_FRAME = 2'd0,
        OP_BIN   = 2'd1,
        OP_DRAIN = 2'd2,
        OP_START = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_LEVELS   = 2'd0,
        KIND_BEAT     = 2'd1,
        KIND_SPECTRUM = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        REG_RESPONSE_BAND = 2'd0,
        REG_BEAT_FLOOR    = 2'd1,
        REG_BEAT_RISE     = 2'd2,
        REG_REFRACTORY    = 2'd3
    } cfg_reg_t;

    localparam int LEVELS = 5;

    localparam logic [2:0]  RESPONSE_BAND_RESET = 3'd1;
    localparam logic [7:0]  BEAT_FLOOR_RESET    = 8'd40;
    localparam logic [7:0]  BEAT_RISE_RESET     = 8'd25;
    localparam logic [15:0] REFRACTORY_RESET    = 16'd140;

    localparam logic [2:0]  MAX_BAND            = 3'd4;
    localparam logic [31:0] START_LAST_BEAT_AGO = 32'd200;
    localparam logic [31:0] BAND2_FIRST_BIN     = 32'd5;
    localparam logic [31:0] BAND3_FIRST_BIN     = 32'd26;

    function automatic logic [7:0] hold_max(input logic keep, input logic [7:0] old_v,
                                            input logic [7:0] new_v);
        return (keep && (old_v > new_v)) ? old_v : new_v;
    endfunction

endpackage

FILE: hw/rtl/abdph_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module abdph_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                                      aclk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

FILE: hw/rtl/audio_beat_detect_peak_hold.sv
// ----------------------------------------------------------------------------
// Beat detector with peak hold
// A frame transfer tests for a beat and stores it when one is found; when
// the bins are derived from the levels, it then reads and rewrites the
// spectrum RAM one row of eight bins at a time. A bin transfer with an index
// inside the spectrum rewrites its row, and a start transfer arms the time
// of the last beat. A drain emits 1 + BEAT_SLOTS + SPECTRUM_BINS/8 words,
// each held until the output takes it. No new input is taken until the
// block is idle again. All time arithmetic shares one 32-bit subtractor,
// and the spectrum RAM has a single read port.
// ----------------------------------------------------------------------------
`include "audio_beat_detect_peak_hold_defines.svh"

module audio_beat_detect_peak_hold import abdph_pkg::*; #(
    parameter int SPECTRUM_BINS = 64,
    parameter int BEAT_SLOTS    = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // now_ms[31:0], level_0..level_4[71:32], has_spectrum[72],
    // bin_index[78:73], bin_value[86:79], zero fill[87].
    input  logic [87:0] s_tdata,
    // operation[1:0].
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // word_index[2:0], word_data[66:3], zero fill[71:67].
    output logic [71:0] m_tdata,
    // word_kind[1:0], was_pending[2].
    output logic [2:0]  m_tuser,
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int ROWS   = SPECTRUM_BINS / 8;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int SLOT_W = (BEAT_SLOTS > 1) ? $clog2(BEAT_SLOTS) : 1;
    localparam int IDX_W  = (ROW_W > SLOT_W) ? ROW_W : SLOT_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ARM,
        ST_TEST,
        ST_STORE,
        ST_FILL_RD,
        ST_FILL_WR,
        ST_BIN_WR,
        ST_OUT_RD,
        ST_OUT_LOAD,
        ST_OUT_WAIT
    } state_t;

    state_t state_reg;

    logic [2:0]  response_band_reg;
    logic [7:0]  beat_floor_reg;
    logic [7:0]  beat_rise_reg;
    logic [15:0] refractory_reg;

    logic [31:0] start_time_reg;
    logic [31:0] last_beat_reg;
    logic [7:0]  prev_sel_reg;
    logic [7:0]  beat_count_reg;
    logic [SLOT_W-1:0] slot_ptr_reg;
    logic [31:0] beat_times_reg [BEAT_SLOTS];
    logic [7:0]  held_lv_reg [LEVELS];
    logic        pending_reg;
    logic        prior_pending_reg;
    logic [ROWS-1:0] row_valid_reg;

    logic [31:0] now_reg;
    logic [7:0]  lv1_reg;
    logic [7:0]  lv2_reg;
    logic [7:0]  lv3_reg;
    logic        has_spec_reg;
    logic        beat_cand_reg;
    logic [ROW_W-1:0] bin_row_reg;
    logic [2:0]  bin_byte_reg;
    logic [7:0]  bin_val_reg;
    logic [ROW_W-1:0] rd_row_reg;

    kind_t       kind_reg;
    logic [IDX_W-1:0] idx_reg;

    logic        out_valid_reg;
    kind_t       out_kind_reg;
    logic [2:0]  out_index_reg;
    logic [63:0] out_data_reg;
    logic        out_last_reg;
    logic        was_reg;

    logic [7:0]  in_level [LEVELS];
    logic [31:0] in_now;
    logic        in_has_spec;
    logic [31:0] in_bin_full;
    logic [7:0]  in_bin_val;
    op_t         in_op;
    logic        in_xfer;
    logic        out_xfer;

    logic [2:0]  band;
    logic [2:0]  sel_idx;
    logic [7:0]  sel;
    logic [8:0]  rise_sum;
    logic        beat_cand;

    logic [31:0] sub_b;
    logic [31:0] sub_out;

    logic [ROW_W-1:0] row_idx;
    logic [31:0] row_idx_full;
    logic [ROW_W-1:0] ram_raddr;
    logic [ROW_W-1:0] ram_waddr;
    logic        ram_we;
    logic [63:0] ram_wdata;
    logic [63:0] ram_rdata;
    logic [63:0] row_data;
    logic [63:0] fill_row;
    logic [63:0] bin_row;
    logic [31:0] idx_full;
    logic        out_last;

    always_comb begin
        for (int i = 0; i < LEVELS; i++) begin
            in_level[i] = s_tdata[32 + 8 * i +: 8];
        end
    end

    assign in_now      = s_tdata[31:0];
    assign in_has_spec = s_tdata[72];
    assign in_bin_full = 32'(s_tdata[78:73]);
    assign in_bin_val  = s_tdata[86:79];
    assign in_op       = op_t'(s_tuser);

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign out_xfer  = m_tvalid && m_tready;
    assign cfg_ready = 1'b1;

    assign band     = (response_band_reg > MAX_BAND) ? MAX_BAND : response_band_reg;
    assign sel_idx  = (band == 3'd0) ? 3'd1 : band;
    assign sel      = in_level[sel_idx];
    assign rise_sum = {1'b0, prev_sel_reg} + {1'b0, beat_rise_reg};
    assign beat_cand = (band != 3'd0)
                     ? ((sel > beat_floor_reg) && ({1'b0, sel} > rise_sum))
                     : (in_level[4] != 8'd0);

    always_comb begin
        unique case (state_reg)
            ST_TEST:  sub_b = last_beat_reg;
            ST_STORE: sub_b = start_time_reg;
            default:  sub_b = START_LAST_BEAT_AGO;
        endcase
    end
    assign sub_out = now_reg - sub_b;

    assign row_idx      = idx_reg[ROW_W-1:0];
    assign row_idx_full = 32'(row_idx);
    assign idx_full     = 32'(idx_reg);
    assign ram_raddr    = (state_reg == ST_IDLE) ? in_bin_full[3 +: ROW_W] : row_idx;
    assign ram_waddr    = (state_reg == ST_BIN_WR) ? bin_row_reg : row_idx;
    assign ram_we       = (state_reg == ST_FILL_WR) || (state_reg == ST_BIN_WR);
    assign ram_wdata    = (state_reg == ST_BIN_WR) ? bin_row : fill_row;
    assign row_data     = row_valid_reg[rd_row_reg] ? ram_rdata : 64'd0;

    always_comb begin
        logic [31:0] bin_num;
        logic [7:0]  derived;
        for (int j = 0; j < 8; j++) begin
            bin_num = {row_idx_full[28:0], 3'(j)};
            if (bin_num < BAND2_FIRST_BIN) begin
                derived = lv1_reg;
            end else if (bin_num < BAND3_FIRST_BIN) begin
                derived = lv2_reg;
            end else begin
                derived = lv3_reg;
            end
            fill_row[8 * j +: 8] = hold_max(prior_pending_reg, row_data[8 * j +: 8], derived);
        end
    end

    always_comb begin
        bin_row = row_data;
        bin_row[8 * bin_byte_reg +: 8] =
            hold_max(prior_pending_reg, row_data[8 * bin_byte_reg +: 8], bin_val_reg);
    end

    assign out_last = (kind_reg == KIND_SPECTRUM) && (idx_reg == IDX_W'(ROWS - 1));

    abdph_ram #(
        .WIDTH (64),
        .DEPTH (ROWS)
    ) u_spectrum_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        rd_row_reg <= ram_raddr;
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            response_band_reg <= RESPONSE_BAND_RESET;
            beat_floor_reg    <= BEAT_FLOOR_RESET;
            beat_rise_reg     <= BEAT_RISE_RESET;
            refractory_reg    <= REFRACTORY_RESET;
            start_time_reg    <= '0;
            last_beat_reg     <= '0;
            prev_sel_reg      <= '0;
            beat_count_reg    <= '0;
            slot_ptr_reg      <= '0;
            for (int i = 0; i < BEAT_SLOTS; i++) begin
                beat_times_reg[i] <= '1;
            end
            for (int i = 0; i < LEVELS; i++) begin
                held_lv_reg[i] <= '0;
            end
            pending_reg       <= 1'b0;
            prior_pending_reg <= 1'b0;
            row_valid_reg     <= '0;
            kind_reg          <= KIND_LEVELS;
            idx_reg           <= '0;
            out_valid_reg     <= 1'b0;
            out_kind_reg      <= KIND_LEVELS;
            out_index_reg     <= '0;
            out_last_reg      <= 1'b0;
            was_reg           <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_RESPONSE_BAND: response_band_reg <= cfg_data[2:0];
                    REG_BEAT_FLOOR:    beat_floor_reg    <= cfg_data[7:0];
                    REG_BEAT_RISE:     beat_rise_reg     <= cfg_data[7:0];
                    REG_REFRACTORY:    refractory_reg    <= cfg_data;
                    default: ;
                endcase
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (in_xfer) begin
                        unique case (in_op)
                            OP_FRAME: begin
                                now_reg           <= in_now;
                                lv1_reg           <= in_level[1];
                                lv2_reg           <= in_level[2];
                                lv3_reg           <= in_level[3];
                                has_spec_reg      <= in_has_spec;
                                beat_cand_reg     <= beat_cand;
                                prev_sel_reg      <= sel;
                                prior_pending_reg <= pending_reg;
                                pending_reg       <= 1'b1;
                                for (int i = 0; i < LEVELS; i++) begin
                                    held_lv_reg[i] <= hold_max(pending_reg, held_lv_reg[i],
                                                               in_level[i]);
                                end
                                state_reg <= ST_TEST;
                            end
                            OP_BIN: begin
                                bin_row_reg  <= in_bin_full[3 +: ROW_W];
                                bin_byte_reg <= in_bin_full[2:0];
                                bin_val_reg  <= in_bin_val;
                                if (in_bin_full < 32'(SPECTRUM_BINS)) begin
                                    state_reg <= ST_BIN_WR;
                                end
                            end
                            OP_DRAIN: begin
                                was_reg     <= pending_reg;
                                pending_reg <= 1'b0;
                                kind_reg    <= KIND_LEVELS;
                                idx_reg     <= '0;
                                state_reg   <= ST_OUT_RD;
                            end
                            OP_START: begin
                                now_reg           <= in_now;
                                start_time_reg    <= in_now;
                                prev_sel_reg      <= '0;
                                beat_count_reg    <= '0;
                                slot_ptr_reg      <= '0;
                                for (int i = 0; i < BEAT_SLOTS; i++) begin
                                    beat_times_reg[i] <= '1;
                                end
                                for (int i = 0; i < LEVELS; i++) begin
                                    held_lv_reg[i] <= '0;
                                end
                                row_valid_reg     <= '0;
                                pending_reg       <= 1'b0;
                                prior_pending_reg <= 1'b0;
                                state_reg         <= ST_ARM;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_ARM: begin
                    last_beat_reg <= sub_out;
                    state_reg     <= ST_IDLE;
                end
                ST_TEST: begin
                    idx_reg <= '0;
                    if (beat_cand_reg && (sub_out > 32'(refractory_reg))) begin
                        last_beat_reg <= now_reg;
                        state_reg     <= ST_STORE;
                    end else begin
                        state_reg <= has_spec_reg ? ST_IDLE : ST_FILL_RD;
                    end
                end
                ST_STORE: begin
                    beat_times_reg[slot_ptr_reg] <= sub_out;
                    beat_count_reg <= beat_count_reg + 8'd1;
                    if ((beat_count_reg == 8'hFF) ||
                        (slot_ptr_reg == SLOT_W'(BEAT_SLOTS - 1))) begin
                        slot_ptr_reg <= '0;
                    end else begin
                        slot_ptr_reg <= slot_ptr_reg + SLOT_W'(1);
                    end
                    state_reg <= has_spec_reg ? ST_IDLE : ST_FILL_RD;
                end
                ST_FILL_RD: begin
                    state_reg <= ST_FILL_WR;
                end
                ST_FILL_WR: begin
                    row_valid_reg[row_idx] <= 1'b1;
                    if (idx_reg == IDX_W'(ROWS - 1)) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        idx_reg   <= idx_reg + IDX_W'(1);
                        state_reg <= ST_FILL_RD;
                    end
                end
                ST_BIN_WR: begin
                    row_valid_reg[bin_row_reg] <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                ST_OUT_RD: begin
                    state_reg <= ST_OUT_LOAD;
                end
                ST_OUT_LOAD: begin
                    out_valid_reg <= 1'b1;
                    out_kind_reg  <= kind_reg;
                    out_index_reg <= idx_full[2:0];
                    out_last_reg  <= out_last;
                    unique case (kind_reg)
                        KIND_LEVELS: begin
                            out_data_reg <= {16'd0, beat_count_reg, held_lv_reg[4],
                                             held_lv_reg[3], held_lv_reg[2],
                                             held_lv_reg[1], held_lv_reg[0]};
                        end
                        KIND_BEAT: begin
                            out_data_reg <= {32'd0, beat_times_reg[idx_reg[SLOT_W-1:0]]};
                        end
                        KIND_SPECTRUM: begin
                            out_data_reg <= row_data;
                        end
                        default: begin
                            out_data_reg <= '0;
                        end
                    endcase
                    state_reg <= ST_OUT_WAIT;
                end
                ST_OUT_WAIT: begin
                    if (out_xfer) begin
                        out_valid_reg <= 1'b0;
                        if (out_last_reg) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            state_reg <= ST_OUT_RD;
                            unique case (kind_reg)
                                KIND_LEVELS: begin
                                    kind_reg <= KIND_BEAT;
                                    idx_reg  <= '0;
                                end
                                KIND_BEAT: begin
                                    if (idx_reg == IDX_W'(BEAT_SLOTS - 1)) begin
                                        kind_reg <= KIND_SPECTRUM;
                                        idx_reg  <= '0;
                                    end else begin
                                        idx_reg <= idx_reg + IDX_W'(1);
                                    end
                                end
                                default: begin
                                    idx_reg <= idx_reg + IDX_W'(1);
                                end
                            endcase
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_data_reg, out_index_reg};
    assign m_tuser  = {was_reg, out_kind_reg};
    assign m_tlast  = out_last_reg;

    `ABDPH_ASSERT_NOW(a_no_input_while_output, aclk, aresetn,
        m_tvalid, !s_tready, "input accepted while a result is waiting")
    `ABDPH_ASSERT_NOW(a_last_is_spectrum, aclk, aresetn,
        m_tvalid && m_tlast, m_tuser[1:0] == KIND_SPECTRUM,
        "final drain word is not a spectrum word")
    `ABDPH_ASSERT_NEXT(a_idle_after_last, aclk, aresetn,
        m_tvalid && m_tready && m_tlast, s_tready,
        "block not ready after the final drain transfer")
    `ABDPH_ASSERT_NEXT(a_drain_clears_pending, aclk, aresetn,
        s_tvalid && s_tready && (s_tuser == OP_DRAIN), !pending_reg && !s_tready,
        "drain did not clear pending or left the block ready")

endmodule

FILE: verif/tb_audio_beat_detect_peak_hold.sv
// ----------------------------------------------------------------------------
// Testbench for the beat detector with peak hold
// Drives frame, bin, drain and start transfers into the block and checks
// every drained word against a cycle-free model of the detector kept in
// this file. A short table of directed transfers comes first, followed by
// phases of random timelines under different register settings, with
// random idle bursts on both sides, a long output stall and a pause
// until all drained words have arrived.
// ----------------------------------------------------------------------------
module tb_audio_beat_detect_peak_hold import abdph_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SPECTRUM_BINS = 64;
    localparam int BEAT_SLOTS    = 4;
    localparam int SLOT_W        = $clog2(BEAT_SLOTS);
    localparam int SPEC_WORDS    = SPECTRUM_BINS / 8;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 42;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_OFF      = 400;

    typedef struct packed {
        logic                   fill;
        logic [7:0]             bin_value;
        logic [5:0]             bin_index;
        logic                   has_spectrum;
        logic [LEVELS-1:0][7:0] level;
        logic [31:0]            now_ms;
    } audio_item_t;

    typedef struct packed {
        kind_t       kind;
        logic [2:0]  index;
        logic [63:0] data;
        logic        was;
        logic        last;
    } drain_word_t;

    typedef struct {
        op_t         op;
        audio_item_t item;
        logic        typed;
        logic [63:0] typed_lvl_word;
        logic [31:0] typed_beat;
        logic [7:0]  typed_bin;
        logic        typed_was;
    } stim_row_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [71:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    audio_beat_detect_peak_hold #(
        .SPECTRUM_BINS(SPECTRUM_BINS),
        .BEAT_SLOTS   (BEAT_SLOTS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    logic [2:0]  cfg_band  = RESPONSE_BAND_RESET;
    logic [7:0]  cfg_floor = BEAT_FLOOR_RESET;
    logic [7:0]  cfg_rise  = BEAT_RISE_RESET;
    logic [15:0] cfg_refr  = REFRACTORY_RESET;

    logic [31:0] start_t;
    logic [31:0] last_beat_t;
    logic [7:0]  prev_sel;
    logic [7:0]  beat_cnt;
    logic [31:0] beat_slot [BEAT_SLOTS];
    logic [7:0]  held_lvl [LEVELS];
    logic [7:0]  held_bin [SPECTRUM_BINS];
    logic        held_pending;
    logic        prior_pending;

    drain_word_t due_words [$];
    stim_row_t   stim_table [$];

    int unsigned src_idle_pct  = 0;
    int unsigned sink_idle_pct = 0;
    logic        hold_off_req  = 1'b0;
    logic [31:0] cur_now       = '0;

    int mismatches      = 0;
    int items_sent      = 0;
    int drains_sent     = 0;
    int beats_predicted = 0;
    int words_seen      = 0;
    int settings_used   = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("Timeout with %0d drained words outstanding.", due_words.size());
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [7:0] peak_of(input logic keep, input logic [7:0] old_v,
                                           input logic [7:0] new_v);
        return (keep && old_v > new_v) ? old_v : new_v;
    endfunction

    function automatic void restart_timeline(input logic [31:0] now);
        start_t       = now;
        last_beat_t   = now - START_LAST_BEAT_AGO;
        prev_sel      = '0;
        beat_cnt      = '0;
        held_pending  = 1'b0;
        prior_pending = 1'b0;
        for (int i = 0; i < BEAT_SLOTS; i++) beat_slot[i] = '1;
        for (int i = 0; i < LEVELS; i++) held_lvl[i] = '0;
        for (int i = 0; i < SPECTRUM_BINS; i++) held_bin[i] = '0;
    endfunction

    function automatic void track_frame(input audio_item_t it);
        logic [2:0] band;
        logic [7:0] sel;
        logic [8:0] need;
        logic       beat;
        logic [7:0] v;
        band = (cfg_band > MAX_BAND) ? MAX_BAND : cfg_band;
        sel  = it.level[(band != 3'd0) ? band : 3'd1];
        need = {1'b0, prev_sel} + {1'b0, cfg_rise};
        if (band != 3'd0) beat = (sel > cfg_floor) && ({1'b0, sel} > need);
        else beat = it.level[4] != 8'd0;
        prev_sel = sel;
        if (beat && (it.now_ms - last_beat_t) > {16'd0, cfg_refr}) begin
            last_beat_t = it.now_ms;
            beat_slot[SLOT_W'(beat_cnt % BEAT_SLOTS)] = it.now_ms - start_t;
            beat_cnt = beat_cnt + 8'd1;
            beats_predicted++;
        end
        prior_pending = held_pending;
        for (int i = 0; i < LEVELS; i++)
            held_lvl[i] = peak_of(held_pending, held_lvl[i], it.level[i]);
        if (!it.has_spectrum) begin
            for (int i = 0; i < SPECTRUM_BINS; i++) begin
                if (i < BAND2_FIRST_BIN) v = it.level[1];
                else if (i < BAND3_FIRST_BIN) v = it.level[2];
                else v = it.level[3];
                held_bin[i] = peak_of(held_pending, held_bin[i], v);
            end
        end
        held_pending = 1'b1;
    endfunction

    function automatic void push_word(input kind_t kind, input logic [2:0] index,
                                      input logic [63:0] data, input logic was,
                                      input logic last);
        drain_word_t w;
        w.kind  = kind;
        w.index = index;
        w.data  = data;
        w.was   = was;
        w.last  = last;
        due_words.push_back(w);
    endfunction

    // Typed rows replace the computed contents but still clear the pending flag.
    function automatic void predict_drain(input stim_row_t r);
        logic [63:0] d;
        logic        was;
        was = r.typed ? r.typed_was : held_pending;
        d = '0;
        for (int i = 0; i < LEVELS; i++) d[8*i +: 8] = held_lvl[i];
        d[47:40] = beat_cnt;
        push_word(KIND_LEVELS, 3'd0, r.typed ? r.typed_lvl_word : d, was, 1'b0);
        for (int i = 0; i < BEAT_SLOTS; i++)
            push_word(KIND_BEAT, 3'(i), {32'd0, r.typed ? r.typed_beat : beat_slot[i]},
                      was, 1'b0);
        for (int w = 0; w < SPEC_WORDS; w++) begin
            for (int j = 0; j < 8; j++) d[8*j +: 8] = r.typed ? r.typed_bin : held_bin[8*w + j];
            push_word(KIND_SPECTRUM, 3'(w), d, was, w == SPEC_WORDS - 1);
        end
        held_pending = 1'b0;
    endfunction

    task automatic note_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("[%0t] mismatch in %s of word %0d: got %h, want %h",
                 $time, field, words_seen, got, want);
        mismatches++;
    endtask

    task automatic check_word();
        drain_word_t want;
        words_seen++;
        if (due_words.size() == 0) begin
            note_mismatch("unexpected word", m_tdata[66:3], 64'd0);
            return;
        end
        want = due_words.pop_front();
        if (m_tuser[1:0] !== want.kind)
            note_mismatch("word_kind", 64'(m_tuser[1:0]), 64'(want.kind));
        if (m_tdata[2:0] !== want.index)
            note_mismatch("word_index", 64'(m_tdata[2:0]), 64'(want.index));
        if (m_tdata[66:3] !== want.data)
            note_mismatch("word_data", m_tdata[66:3], want.data);
        if (m_tuser[2] !== want.was)
            note_mismatch("was_pending", 64'(m_tuser[2]), 64'(want.was));
        if (m_tlast !== want.last)
            note_mismatch("last", 64'(m_tlast), 64'(want.last));
    endtask

    initial begin
        int gap;
        int hold_left;
        gap = 0;
        hold_left = 0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) check_word();
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left = HOLD_OFF;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (gap > 0) begin
                gap--;
                m_tready <= 1'b0;
            end else if (sink_idle_pct != 0 && $urandom_range(0, 99) < sink_idle_pct) begin
                gap = $urandom_range(1, 19) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_row(input stim_row_t r);
        if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.op;
        s_tdata  <= r.item;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        case (r.op)
            OP_FRAME: track_frame(r.item);
            OP_BIN:   held_bin[r.item.bin_index] =
                          peak_of(prior_pending, held_bin[r.item.bin_index], r.item.bin_value);
            OP_START: restart_timeline(r.item.now_ms);
            default: begin
                drains_sent++;
                predict_drain(r);
            end
        endcase
    endtask

    task automatic write_reg(input cfg_reg_t index, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (index)
            REG_RESPONSE_BAND: cfg_band  = value[2:0];
            REG_BEAT_FLOOR:    cfg_floor = value[7:0];
            REG_BEAT_RISE:     cfg_rise  = value[7:0];
            default:           cfg_refr  = value;
        endcase
    endtask

    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        while (due_words.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic audio_item_t random_item();
        logic [95:0] raw;
        audio_item_t it;
        raw = {$urandom, $urandom, $urandom};
        it = raw[87:0];
        it.fill = 1'b0;
        return it;
    endfunction

    function automatic logic [7:0] random_level();
        case ($urandom_range(0, 5))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic add_row(input op_t op, input logic [31:0] now, input logic [39:0] lv,
                           input logic spec, input logic [5:0] bidx, input logic [7:0] bval);
        stim_row_t r;
        r.op                = op;
        r.item.fill         = 1'b0;
        r.item.bin_value    = bval;
        r.item.bin_index    = bidx;
        r.item.has_spectrum = spec;
        r.item.level        = lv;
        r.item.now_ms       = now;
        r.typed             = 1'b0;
        r.typed_lvl_word    = '0;
        r.typed_beat        = '0;
        r.typed_bin         = '0;
        r.typed_was         = 1'b0;
        stim_table.push_back(r);
    endtask

    task automatic add_typed_drain(input logic [63:0] lvl_word, input logic [31:0] beat,
                                   input logic [7:0] bin, input logic was);
        add_row(OP_DRAIN, 32'd0, 40'd0, 1'b0, 6'd0, 8'd0);
        stim_table[$].typed          = 1'b1;
        stim_table[$].typed_lvl_word = lvl_word;
        stim_table[$].typed_beat     = beat;
        stim_table[$].typed_bin      = bin;
        stim_table[$].typed_was      = was;
    endtask

    task automatic run_random(input int count, input int ph);
        stim_row_t r;
        int n;
        int pick;
        logic stalled;
        logic paused;
        stalled          = 1'b0;
        paused           = 1'b0;
        r.typed          = 1'b0;
        r.typed_lvl_word = '0;
        r.typed_beat     = '0;
        r.typed_bin      = '0;
        r.typed_was      = 1'b0;
        cur_now = $urandom;
        if ($urandom_range(0, 3) == 0) cur_now = 32'hFFFF_FFFF - 32'($urandom_range(0, 2000));
        r.op = OP_START;
        r.item = random_item();
        r.item.now_ms = cur_now;
        send_row(r);
        n = 1;
        while (n < count) begin
            if (ph == 3 && !stalled && n >= 10) begin
                stalled = 1'b1;
                hold_off_req = 1'b1;
                repeat (6) begin
                    r.op = OP_DRAIN;
                    r.item = random_item();
                    send_row(r);
                    n++;
                end
            end
            if (ph == 2 && !paused && n >= 20) begin
                paused = 1'b1;
                s_tvalid <= 1'b0;
                do @(posedge aclk); while (due_words.size() != 0);
            end
            pick = $urandom_range(0, 99);
            r.item = random_item();
            if (pick < 55) begin
                if ($urandom_range(0, 19) == 0) cur_now = cur_now + $urandom;
                else cur_now = cur_now + 32'($urandom_range(0, 300));
                r.op = OP_FRAME;
                r.item.now_ms = cur_now;
                for (int i = 0; i < LEVELS; i++) r.item.level[i] = random_level();
                send_row(r);
                n++;
                if (r.item.has_spectrum) begin
                    repeat ($urandom_range(1, 4)) begin
                        r.op = OP_BIN;
                        r.item = random_item();
                        send_row(r);
                        n++;
                    end
                end
            end else if (pick < 75) begin
                r.op = OP_BIN;
                send_row(r);
                n++;
            end else if (pick < 87) begin
                r.op = OP_DRAIN;
                send_row(r);
                n++;
            end else if (pick < 92) begin
                cur_now = r.item.now_ms;
                r.op = OP_START;
                send_row(r);
                n++;
            end else begin
                r.op = op_t'(2'($urandom_range(0, 3)));
                send_row(r);
                n++;
            end
        end
    endtask

    initial begin
        int          guard;
        logic [2:0]  band;
        logic [7:0]  flr;
        logic [7:0]  rse;
        logic [15:0] refr;

        restart_timeline(32'd0);
        start_t     = '0;
        last_beat_t = '0;

        add_typed_drain(64'd0, 32'hFFFF_FFFF, 8'h00, 1'b0);
        add_row(OP_START, 32'd1000, 40'd0, 1'b0, 6'd0, 8'd0);
        add_typed_drain(64'd0, 32'hFFFF_FFFF, 8'h00, 1'b0);
        add_row(OP_FRAME, 32'd1000, 40'd0, 1'b0, 6'd0, 8'd0);
        add_typed_drain(64'd0, 32'hFFFF_FFFF, 8'h00, 1'b1);
        add_row(OP_FRAME, 32'd1100, 40'hFF_FFFF_FFFF, 1'b0, 6'd0, 8'd0);
        add_row(OP_FRAME, 32'd1150, 40'hFF_FFFF_FFFF, 1'b0, 6'd0, 8'd0);
        add_row(OP_BIN, 32'd0, 40'd0, 1'b0, 6'd0, 8'd0);
        add_row(OP_BIN, 32'd0, 40'd0, 1'b0, 6'd63, 8'd255);
        add_row(OP_FRAME, 32'd1300, 40'h28_1E_14_3C_0A, 1'b1, 6'd0, 8'd0);
        add_row(OP_BIN, 32'd0, 40'd0, 1'b0, 6'd63, 8'd200);
        add_row(OP_BIN, 32'd0, 40'd0, 1'b0, 6'd5, 8'd1);
        add_row(OP_DRAIN, 32'd0, 40'd0, 1'b0, 6'd0, 8'd0);
        add_row(OP_DRAIN, 32'd0, 40'd0, 1'b0, 6'd0, 8'd0);
        add_row(OP_FRAME, 32'hFFFF_FFFF, 40'h05_04_03_02_01, 1'b0, 6'd0, 8'd0);
        add_row(OP_BIN, 32'd0, 40'd0, 1'b0, 6'd20, 8'hAA);
        add_row(OP_DRAIN, 32'd0, 40'd0, 1'b0, 6'd0, 8'd0);
        add_row(OP_START, 32'hFFFF_FF00, 40'd0, 1'b0, 6'd0, 8'd0);
        add_row(OP_FRAME, 32'h0000_0010, 40'h00_00_00_C8_00, 1'b0, 6'd0, 8'd0);
        add_row(OP_FRAME, 32'h0000_0020, 40'd0, 1'b0, 6'd0, 8'd0);
        add_row(OP_FRAME, 32'h0000_0030, 40'h00_00_00_FF_00, 1'b0, 6'd0, 8'd0);
        add_row(OP_FRAME, 32'h0000_0100, 40'd0, 1'b0, 6'd0, 8'd0);
        add_row(OP_FRAME, 32'h0000_0200, 40'h00_00_00_FF_00, 1'b0, 6'd0, 8'd0);
        add_row(OP_DRAIN, 32'd0, 40'd0, 1'b0, 6'd0, 8'd0);

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        src_idle_pct  = 15;
        sink_idle_pct = 15;
        foreach (stim_table[i]) send_row(stim_table[i]);

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_quiet();
            case (ph)
                0: begin band = 3'd0; flr = 8'd40;  rse = 8'd25;  refr = 16'd140;   end
                1: begin band = 3'd4; flr = 8'd0;   rse = 8'd0;   refr = 16'd0;     end
                2: begin band = 3'd7; flr = 8'd255; rse = 8'd255; refr = 16'hFFFF;  end
                3: begin band = 3'd2; flr = 8'd10;  rse = 8'd5;   refr = 16'd30;    end
                4: begin band = 3'd3; flr = 8'd100; rse = 8'd0;   refr = 16'd500;   end
                default: begin
                    band = 3'($urandom_range(0, 7));
                    flr  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                       : 8'($urandom_range(0, 80));
                    rse  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                       : 8'($urandom_range(0, 60));
                    refr = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 65535))
                                                       : 16'($urandom_range(0, 300));
                end
            endcase
            write_reg(REG_RESPONSE_BAND, {13'($urandom), band});
            write_reg(REG_BEAT_FLOOR, {8'($urandom), flr});
            write_reg(REG_BEAT_RISE, {8'($urandom), rse});
            write_reg(REG_REFRACTORY, refr);
            cfg_valid <= 1'b0;
            settings_used++;
            if (ph == PHASES - 1) begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end else begin
                src_idle_pct  = (ph % 3 == 1) ? 0 : $urandom_range(5, 30);
                sink_idle_pct = (ph % 3 == 2) ? 0 : $urandom_range(5, 30);
            end
            run_random(PHASE_ITEMS, ph);
        end

        s_tvalid <= 1'b0;
        for (guard = 0; guard < 200000 && due_words.size() != 0; guard++) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (due_words.size() != 0)
            note_mismatch("missing words", 64'(due_words.size()), 64'd0);

        $display("Sent %0d transfers (%0d drains) under %0d register settings; %0d beats.",
                 items_sent, drains_sent, settings_used + 1, beats_predicted);
        $display("Checked %0d drained words, with %0d mismatches.", words_seen, mismatches);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
